### hdl/pgtl_pkg.sv
// shared types and constants for the periodic grid trilinear lookup
package pgtl_pkg;

	localparam int DEFAULT_TABLE_DEPTH = 16384;
	localparam int MAX_POINTS = 64;

	localparam int VALUE_W = 16;
	localparam int POINTS_W = 7;
	localparam int STRIDE_W = 9;
	localparam int ADDR_IN_W = 14;
	localparam int COEF_W = 32;
	localparam int Q_W = 32;
	localparam int CHAN_W = 8;
	localparam int FRAC_W = 16;
	localparam int WEIGHT_W = 17;
	localparam int MUL_W = 34;
	localparam int AXES = 3;
	localparam int MATRIX_ENTRIES = 9;

	localparam logic [WEIGHT_W-1:0] ONE_Q16 = 17'h10000;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W = 9;

	localparam logic [CFG_INDEX_W-1:0] CFG_POINTS_X = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_POINTS_Y = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_POINTS_Z = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_CHANNELS = 2'd3;

	localparam logic [1:0] ACT_TABLE_WRITE = 2'd0;
	localparam logic [1:0] ACT_COEF_WRITE = 2'd1;
	localparam logic [1:0] ACT_QUERY = 2'd2;

	typedef struct packed {
		logic [1:0] action;
		logic [ADDR_IN_W-1:0] write_address;
		logic [VALUE_W-1:0] table_word;
		logic signed [COEF_W-1:0] coefficient;
		logic signed [Q_W-1:0] q_x;
		logic signed [Q_W-1:0] q_y;
		logic signed [Q_W-1:0] q_z;
		logic [CHAN_W-1:0] channel;
	} pgtl_req_t;

	typedef struct packed {
		logic [VALUE_W-1:0] interpolated_value;
		logic range_error;
	} pgtl_rsp_t;

	// grid points saturated into 2..MAX_POINTS
	function automatic logic [POINTS_W-1:0] eff_points(input logic [POINTS_W-1:0] p);
		if (p < POINTS_W'(2)) begin
			return POINTS_W'(2);
		end else if (int'(p) > MAX_POINTS) begin
			return POINTS_W'(MAX_POINTS);
		end else begin
			return p;
		end
	endfunction

endpackage

### hdl/periodic_grid_trilinear_lookup.sv
// periodic 3-d grid lookup with trilinear interpolation, one shared multiplier
// A request word either writes one table word, writes one matrix coefficient
// (index 0..8, row-major) or runs a query. A write leaves the sequencer in idle
// and the block stays ready. A query maps Q through the matrix, folds each
// coordinate to a 16-bit fraction, scales it into a cell index and remainder,
// and blends the requested channel from the eight cell corners. All products
// go through one registered 34x34 multiplier under a sequencer, and corners are
// read one at a time from the single table read port, so a query keeps the
// block busy until its result is registered, longer for each corner with
// nonzero weight that falls inside the table and longer still while an
// earlier result waits to be taken. The result register lets the next
// request in while a result waits to be taken. Table and matrix entries hold
// no defined value until written; there is no clearing pass after reset.
module periodic_grid_trilinear_lookup
	import pgtl_pkg::*;
#(
	parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic req_valid,
	output logic req_ready,
	input  pgtl_req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output pgtl_rsp_t rsp
);

	localparam int ADDR_W = $clog2(TABLE_DEPTH);

	typedef enum logic [3:0] {
		S_IDLE,
		S_MAT,
		S_SCALE,
		S_IDX,
		S_A1,
		S_A2,
		S_A3,
		S_A4,
		S_A5,
		S_A6,
		S_A7,
		S_CW,
		S_CV,
		S_CP,
		S_CACC,
		S_DONE
	} state_t;

	state_t state_q;
	logic [1:0] d_q;
	logic [1:0] j_q;
	logic [3:0] k_q;
	logic [2:0] c_q;
	logic err_q;
	logic rsp_valid_q;
	pgtl_rsp_t rsp_q;
	logic [POINTS_W-1:0] points_x_q, points_y_q, points_z_q;
	logic [STRIDE_W-1:0] stride_q;

	logic signed [COEF_W-1:0] coef_q [MATRIX_ENTRIES];
	logic signed [Q_W-1:0] qv_q [AXES];
	logic [CHAN_W-1:0] chan_q;
	logic [POINTS_W-1:0] n_q [AXES];
	logic [STRIDE_W-1:0] stride_lat_q;
	logic [39:0] acc_q;
	logic [POINTS_W-1:0] idx_q [AXES];
	logic [WEIGHT_W-1:0] rem_q [AXES];
	logic [31:0] base_q, sx_q, sy_q;
	logic [32:0] wyz_q;
	logic [63:0] sum_q;
	logic [63:0] p_q;
	logic [VALUE_W-1:0] rdata_q;

	logic [VALUE_W-1:0] grid_table [TABLE_DEPTH];

	logic req_acc;
	logic signed [MUL_W-1:0] mul_a, mul_b;
	logic signed [2*MUL_W-1:0] prod;
	logic [39:0] row_sum;
	logic [FRAC_W-1:0] frac;
	logic [POINTS_W-1:0] nm1;
	logic [22:0] scaled;
	logic [WEIGHT_W-1:0] wx, wy, wz;
	logic w_zero;
	logic [31:0] corner_addr;
	logic in_range;
	logic tbl_we, tbl_re;
	logic [63:0] rounded;

	assign req_ready = (state_q == S_IDLE);
	assign req_acc = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	assign row_sum = acc_q + p_q[39:0];
	assign frac = row_sum[39:24];
	assign nm1 = n_q[d_q] - POINTS_W'(1);
	assign scaled = p_q[22:0];

	// corner weights, bit 2 of the corner number selects x, bit 0 selects z
	assign wx = c_q[2] ? rem_q[0] : ONE_Q16 - rem_q[0];
	assign wy = c_q[1] ? rem_q[1] : ONE_Q16 - rem_q[1];
	assign wz = c_q[0] ? rem_q[2] : ONE_Q16 - rem_q[2];
	assign w_zero = (wx == '0) || (wy == '0) || (wz == '0);

	assign corner_addr = base_q + (c_q[2] ? sx_q : 32'd0) + (c_q[1] ? sy_q : 32'd0)
		+ (c_q[0] ? 32'(stride_lat_q) : 32'd0);
	assign in_range = corner_addr < 32'(TABLE_DEPTH);

	assign tbl_we = req_acc && (req.action == ACT_TABLE_WRITE)
		&& (32'(req.write_address) < 32'(TABLE_DEPTH));
	assign tbl_re = (state_q == S_CW) && !w_zero && in_range;

	assign rounded = sum_q + 64'h0000_8000_0000_0000;

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_MAT: begin
				mul_a = MUL_W'(coef_q[k_q]);
				mul_b = MUL_W'(qv_q[j_q]);
			end
			S_SCALE: begin
				mul_a = MUL_W'(frac);
				mul_b = MUL_W'(nm1);
			end
			S_A1: begin
				mul_a = MUL_W'(idx_q[0]);
				mul_b = MUL_W'(n_q[1]);
			end
			S_A2: begin
				mul_a = MUL_W'(p_q[31:0] + 32'(idx_q[1]));
				mul_b = MUL_W'(n_q[2]);
			end
			S_A3: begin
				mul_a = MUL_W'(p_q[31:0] + 32'(idx_q[2]));
				mul_b = MUL_W'(stride_lat_q);
			end
			S_A4: begin
				mul_a = MUL_W'(n_q[1]);
				mul_b = MUL_W'(n_q[2]);
			end
			S_A5: begin
				mul_a = MUL_W'(p_q[31:0]);
				mul_b = MUL_W'(stride_lat_q);
			end
			S_A6: begin
				mul_a = MUL_W'(n_q[2]);
				mul_b = MUL_W'(stride_lat_q);
			end
			S_CW: begin
				mul_a = MUL_W'(wy);
				mul_b = MUL_W'(wz);
			end
			S_CV: begin
				mul_a = MUL_W'(rdata_q);
				mul_b = MUL_W'(wx);
			end
			S_CP: begin
				mul_a = MUL_W'(wyz_q);
				mul_b = MUL_W'(p_q[32:0]);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	// sequencer, configuration and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			d_q <= '0;
			j_q <= '0;
			k_q <= '0;
			c_q <= '0;
			err_q <= 1'b0;
			rsp_valid_q <= 1'b0;
			rsp_q <= '0;
			points_x_q <= POINTS_W'(2);
			points_y_q <= POINTS_W'(2);
			points_z_q <= POINTS_W'(2);
			stride_q <= STRIDE_W'(1);
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					CFG_POINTS_X: points_x_q <= cfg_data[POINTS_W-1:0];
					CFG_POINTS_Y: points_y_q <= cfg_data[POINTS_W-1:0];
					CFG_POINTS_Z: points_z_q <= cfg_data[POINTS_W-1:0];
					CFG_CHANNELS: stride_q <= cfg_data;
				endcase
			end
			if (rsp_ready && (state_q != S_DONE)) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_acc && (req.action == ACT_QUERY)) begin
						state_q <= S_MAT;
						d_q <= '0;
						j_q <= '0;
						k_q <= '0;
					end
				end
				S_MAT: begin
					k_q <= k_q + 4'd1;
					if (j_q == 2'd2) begin
						j_q <= '0;
						state_q <= S_SCALE;
					end else begin
						j_q <= j_q + 2'd1;
					end
				end
				S_SCALE: state_q <= S_IDX;
				S_IDX: begin
					if (d_q == 2'd2) begin
						state_q <= S_A1;
					end else begin
						d_q <= d_q + 2'd1;
						state_q <= S_MAT;
					end
				end
				S_A1: state_q <= S_A2;
				S_A2: state_q <= S_A3;
				S_A3: state_q <= S_A4;
				S_A4: state_q <= S_A5;
				S_A5: state_q <= S_A6;
				S_A6: state_q <= S_A7;
				S_A7: begin
					c_q <= '0;
					err_q <= 1'b0;
					state_q <= S_CW;
				end
				S_CW: begin
					if (w_zero || !in_range) begin
						// zero weight corners are never read
						if (!w_zero) begin
							err_q <= 1'b1;
						end
						if (c_q == 3'd7) begin
							state_q <= S_DONE;
						end else begin
							c_q <= c_q + 3'd1;
						end
					end else begin
						state_q <= S_CV;
					end
				end
				S_CV: state_q <= S_CP;
				S_CP: state_q <= S_CACC;
				S_CACC: begin
					if (c_q == 3'd7) begin
						state_q <= S_DONE;
					end else begin
						c_q <= c_q + 3'd1;
						state_q <= S_CW;
					end
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_valid_q <= 1'b1;
						rsp_q.range_error <= err_q;
						rsp_q.interpolated_value <= err_q ? '0 : rounded[63:48];
						state_q <= S_IDLE;
					end
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		p_q <= prod[63:0];
		if (req_acc && (req.action == ACT_COEF_WRITE)
			&& (32'(req.write_address) < 32'(MATRIX_ENTRIES))) begin
			coef_q[req.write_address[3:0]] <= req.coefficient;
		end
		if (req_acc && (req.action == ACT_QUERY)) begin
			qv_q[0] <= req.q_x;
			qv_q[1] <= req.q_y;
			qv_q[2] <= req.q_z;
			chan_q <= req.channel;
			n_q[0] <= eff_points(points_x_q);
			n_q[1] <= eff_points(points_y_q);
			n_q[2] <= eff_points(points_z_q);
			stride_lat_q <= stride_q;
		end
		unique case (state_q)
			S_MAT: begin
				if (j_q == 2'd0) begin
					acc_q <= '0;
				end else begin
					acc_q <= acc_q + p_q[39:0];
				end
			end
			S_IDX: begin
				// past the last cell: stay in the last cell at full remainder
				if (scaled[22:16] >= nm1) begin
					idx_q[d_q] <= n_q[d_q] - POINTS_W'(2);
					rem_q[d_q] <= ONE_Q16;
				end else begin
					idx_q[d_q] <= scaled[22:16];
					rem_q[d_q] <= WEIGHT_W'(scaled[15:0]);
				end
			end
			S_A4: base_q <= p_q[31:0] + 32'(chan_q);
			S_A6: sx_q <= p_q[31:0];
			S_A7: begin
				sy_q <= p_q[31:0];
				sum_q <= '0;
			end
			S_CV: wyz_q <= p_q[32:0];
			S_CACC: sum_q <= sum_q + p_q;
			default: begin
			end
		endcase
	end

	// grid table, one write and one registered read port
	always_ff @(posedge clk) begin
		if (tbl_we) begin
			grid_table[ADDR_W'(req.write_address)] <= req.table_word;
		end
		if (tbl_re) begin
			rdata_q <= grid_table[corner_addr[ADDR_W-1:0]];
		end
	end

	a_err_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.range_error |-> rsp.interpolated_value == '0)
		else $error("range error word carries a nonzero value");

	a_cell_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CW |-> (32'(idx_q[0]) + 32'd2 <= 32'(n_q[0]))
			&& (32'(idx_q[1]) + 32'd2 <= 32'(n_q[1]))
			&& (32'(idx_q[2]) + 32'd2 <= 32'(n_q[2])))
		else $error("cell index past the last cell during corner reads");

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(state_q == S_DONE))
		else $error("result word raised outside the finish step");

endmodule
